// ----- hw/rtl/ses_pkg.sv -----
`timescale 1ns / 1ps

package ses_pkg;

    localparam int MAX_LEN_DEF    = 32;
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int ELEM_W         = 32;
    localparam int POS_W          = 6;

    // Command kinds.
    localparam logic [1:0] KIND_LOAD_A = 2'd0;
    localparam logic [1:0] KIND_LOAD_B = 2'd1;
    localparam logic [1:0] KIND_RUN    = 2'd2;

    // Edit kinds.
    localparam logic [1:0] EDIT_KEEP   = 2'd0;
    localparam logic [1:0] EDIT_INSERT = 2'd1;
    localparam logic [1:0] EDIT_DELETE = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ELEM_W-1:0] element;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        edit_kind;
        logic [POS_W-1:0]  a_position;
        logic [POS_W-1:0]  b_position;
        logic [ELEM_W-1:0] edit_value;
        logic              last;
    } result_t;

    // One entry of the reversed edit list.
    typedef struct packed {
        logic [1:0]       kind;
        logic [POS_W-1:0] a_pos;
        logic [POS_W-1:0] b_pos;
        logic             in_range;
    } edit_t;

endpackage

// ----- hw/rtl/shortest_edit_script.sv -----
`timescale 1ns / 1ps

// Shortest edit script engine (greedy forward search over diagonals).
// Command channel: a transaction is taken on a rising edge with start high and
// busy low. Kind LOAD_A or LOAD_B appends cmd.element to sequence A or B;
// appends beyond MAX_LEN are dropped. Kind RUN clears both lengths when taken
// and computes a shortest edit script from A to B.
// Result channel: each edit is presented for exactly one cycle with
// result_strobe high, first edit first, result.last set on the final one.
// The receiver cannot stall the block; results must be taken when strobed.
// A run has three phases. The search handles each diagonal point in S_RD,
// S_CALC, S_SRD, S_SCMP while pairs match, and S_WR. The backtrack handles
// each edit distance in B_RD1, B_RD2 (skipped at distance zero), B_DEC,
// B_SNK and B_STEP. The drain emits each edit via O_RD, O_LOOK and O_EMIT.
// All of it goes through one sequencer sharing one compare unit and one trace
// memory, so busy stays high for the whole run. A run with both sequences
// empty returns to idle at once with no results.
// Reset clears the lengths and the sequencer; the stores, the trace memory
// and the edit buffer keep no reset and are only read where written.

module shortest_edit_script #(
    parameter int MAX_LEN    = ses_pkg::MAX_LEN_DEF,
    parameter int ELEM_WIDTH = ses_pkg::ELEM_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ses_pkg::cmd_t    cmd,
    output logic             result_strobe,
    output ses_pkg::result_t result
);

    localparam int DMAX = 2 * MAX_LEN;
    localparam int SW   = (ELEM_WIDTH < ses_pkg::ELEM_W) ? ELEM_WIDTH : ses_pkg::ELEM_W;
    localparam int OW   = ses_pkg::ELEM_W;
    localparam int PW   = ses_pkg::POS_W;
    localparam int AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW   = $clog2(MAX_LEN + 1);
    localparam int DW   = $clog2(DMAX + 1);
    localparam int CW   = $clog2(DMAX + 2);
    localparam int BAW  = $clog2(DMAX);
    localparam int XW   = $clog2(5 * MAX_LEN + 1) + 1;
    localparam int VW   = $clog2(3 * MAX_LEN + 1);
    localparam int TD   = (DMAX + 1) * (DMAX + 2) / 2;
    localparam int TW   = $clog2(TD);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_S_RD   = 4'd1;
    localparam logic [3:0] ST_S_CALC = 4'd2;
    localparam logic [3:0] ST_S_SRD  = 4'd3;
    localparam logic [3:0] ST_S_SCMP = 4'd4;
    localparam logic [3:0] ST_S_WR   = 4'd5;
    localparam logic [3:0] ST_B_RD1  = 4'd6;
    localparam logic [3:0] ST_B_RD2  = 4'd7;
    localparam logic [3:0] ST_B_DEC  = 4'd8;
    localparam logic [3:0] ST_B_SNK  = 4'd9;
    localparam logic [3:0] ST_B_STEP = 4'd10;
    localparam logic [3:0] ST_O_RD   = 4'd11;
    localparam logic [3:0] ST_O_LOOK = 4'd12;
    localparam logic [3:0] ST_O_EMIT = 4'd13;

    logic [3:0]           state_reg, state_next;
    logic [LW-1:0]        len_a_reg, len_a_next, len_b_reg, len_b_next;
    logic [LW-1:0]        n_reg, n_next, m_reg, m_next;
    logic [DW-1:0]        d_reg, d_next, idx_reg, idx_next;
    logic [TW-1:0]        base_reg, base_next;
    logic signed [XW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [XW-1:0] px_reg, px_next, py_reg, py_next;
    logic [VW-1:0]        prev_reg, prev_next, cur_reg, cur_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [BAW-1:0]       oidx_reg, oidx_next;

    logic [SW-1:0]        mem_a [MAX_LEN];
    logic [SW-1:0]        mem_b [MAX_LEN];
    logic [VW-1:0]        mem_tr [TD];
    ses_pkg::edit_t       mem_buf [DMAX];

    logic [SW-1:0]        a_rdata, b_rdata;
    logic [AW-1:0]        a_raddr, b_raddr;
    logic                 we_a, we_b;
    logic [VW-1:0]        tr_rdata, tr_wdata;
    logic [TW-1:0]        tr_raddr, tr_waddr, row_prev;
    logic                 tr_we;
    ses_pkg::edit_t       buf_rdata, buf_wdata;
    logic                 buf_we;

    logic signed [XW-1:0] d_s, n_s, m_s, k_bt, kd, j1, j2, k_s, xs, pk, pxs;
    logic                 down;
    logic [SW-1:0]        val;

    function automatic ses_pkg::edit_t mk_edit(input logic [1:0] kind,
                                               input logic signed [XW-1:0] fx,
                                               input logic signed [XW-1:0] fy,
                                               input logic signed [XW-1:0] nn,
                                               input logic signed [XW-1:0] mm);
        ses_pkg::edit_t e;
        e.kind  = kind;
        e.a_pos = (fx < 0) ? '0 : PW'(fx);
        e.b_pos = (fy < 0) ? '0 : PW'(fy);
        if (kind == ses_pkg::EDIT_INSERT) begin
            e.in_range = (fy >= 0) && (fy < mm);
        end else begin
            e.in_range = (fx >= 0) && (fx < nn);
        end
        return e;
    endfunction

    assign d_s      = $signed(XW'(d_reg));
    assign n_s      = $signed(XW'(n_reg));
    assign m_s      = $signed(XW'(m_reg));
    assign k_bt     = x_reg - y_reg;
    assign kd       = k_bt + d_s;
    assign j2       = kd >>> 1;
    assign j1       = j2 - XW'(1);
    assign k_s      = $signed(XW'({idx_reg, 1'b0})) - d_s;
    assign row_prev = base_reg - TW'(d_reg);
    assign busy     = (state_reg != ST_IDLE);

    always_comb begin
        state_next = state_reg;
        len_a_next = len_a_reg;
        len_b_next = len_b_reg;
        n_next     = n_reg;
        m_next     = m_reg;
        d_next     = d_reg;
        idx_next   = idx_reg;
        base_next  = base_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        cnt_next   = cnt_reg;
        oidx_next  = oidx_reg;
        we_a       = 1'b0;
        we_b       = 1'b0;
        tr_we      = 1'b0;
        tr_waddr   = base_reg + TW'(idx_reg);
        tr_wdata   = VW'(x_reg);
        tr_raddr   = row_prev + TW'(idx_reg);
        buf_we     = 1'b0;
        buf_wdata  = mk_edit(ses_pkg::EDIT_KEEP, x_reg - XW'(1), y_reg - XW'(1), n_s, m_s);
        a_raddr    = x_reg[AW-1:0];
        b_raddr    = y_reg[AW-1:0];
        down       = 1'b0;
        xs         = '0;
        pk         = '0;
        pxs        = '0;
        result_strobe = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    case (cmd.kind)
                        ses_pkg::KIND_LOAD_A: begin
                            if (len_a_reg < LW'(MAX_LEN)) begin
                                we_a       = 1'b1;
                                len_a_next = len_a_reg + 1'b1;
                            end
                        end
                        ses_pkg::KIND_LOAD_B: begin
                            if (len_b_reg < LW'(MAX_LEN)) begin
                                we_b       = 1'b1;
                                len_b_next = len_b_reg + 1'b1;
                            end
                        end
                        ses_pkg::KIND_RUN: begin
                            n_next     = len_a_reg;
                            m_next     = len_b_reg;
                            len_a_next = '0;
                            len_b_next = '0;
                            d_next     = '0;
                            idx_next   = '0;
                            base_next  = '0;
                            if (len_a_reg != '0 || len_b_reg != '0) begin
                                state_next = ST_S_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_S_RD: begin
                state_next = ST_S_CALC;
            end
            ST_S_CALC: begin
                // Neighbors k-1 and k+1 come from the previous row: k+1 is read
                // now, k-1 was read on the step before.
                down = (idx_reg == '0) || (idx_reg != d_reg && prev_reg < tr_rdata);
                if (d_reg == '0) begin
                    xs = '0;
                end else if (down) begin
                    xs = $signed(XW'(tr_rdata));
                end else begin
                    xs = $signed(XW'(prev_reg)) + XW'(1);
                end
                cur_next   = tr_rdata;
                x_next     = xs;
                y_next     = xs - k_s;
                state_next = ST_S_SRD;
            end
            ST_S_SRD: begin
                if (x_reg >= 0 && y_reg >= 0 && x_reg < n_s && y_reg < m_s) begin
                    state_next = ST_S_SCMP;
                end else begin
                    state_next = ST_S_WR;
                end
            end
            ST_S_SCMP: begin
                if (a_rdata == b_rdata) begin
                    x_next     = x_reg + XW'(1);
                    y_next     = y_reg + XW'(1);
                    state_next = ST_S_SRD;
                end else begin
                    state_next = ST_S_WR;
                end
            end
            ST_S_WR: begin
                tr_we     = 1'b1;
                prev_next = cur_reg;
                if ((x_reg >= n_s && y_reg >= m_s) ||
                    (idx_reg == d_reg && d_reg == DW'(n_reg) + DW'(m_reg))) begin
                    x_next     = n_s;
                    y_next     = m_s;
                    cnt_next   = '0;
                    state_next = ST_B_RD1;
                end else if (idx_reg == d_reg) begin
                    d_next     = d_reg + 1'b1;
                    base_next  = base_reg + TW'(d_reg) + 1'b1;
                    idx_next   = '0;
                    state_next = ST_S_RD;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_S_RD;
                end
            end
            ST_B_RD1: begin
                tr_raddr = row_prev + ((k_bt == -d_s) ? TW'(j2) : TW'(j1));
                if (d_reg == '0) begin
                    state_next = ST_B_DEC;
                end else begin
                    state_next = ST_B_RD2;
                end
            end
            ST_B_RD2: begin
                cur_next   = tr_rdata;
                tr_raddr   = row_prev + TW'(j2);
                state_next = ST_B_DEC;
            end
            ST_B_DEC: begin
                if (d_reg == '0) begin
                    // Before the first row only diagonal one holds a point.
                    pk  = (k_bt == 0) ? XW'(1) : k_bt - XW'(1);
                    pxs = (pk == 1) ? XW'(0) : -XW'(1);
                end else begin
                    down = (k_bt == -d_s) || (k_bt != d_s && cur_reg < tr_rdata);
                    pk   = down ? k_bt + XW'(1) : k_bt - XW'(1);
                    pxs  = down ? $signed(XW'(tr_rdata)) : $signed(XW'(cur_reg));
                end
                px_next    = pxs;
                py_next    = pxs - pk;
                state_next = ST_B_SNK;
            end
            ST_B_SNK: begin
                if (x_reg > px_reg && y_reg > py_reg && cnt_reg <= CW'(DMAX)) begin
                    buf_we   = (cnt_reg < CW'(DMAX));
                    cnt_next = cnt_reg + 1'b1;
                    x_next   = x_reg - XW'(1);
                    y_next   = y_reg - XW'(1);
                end else begin
                    state_next = ST_B_STEP;
                end
            end
            ST_B_STEP: begin
                if (px_reg == x_reg) begin
                    buf_wdata = mk_edit(ses_pkg::EDIT_INSERT, px_reg, py_reg, n_s, m_s);
                end else if (py_reg == y_reg) begin
                    buf_wdata = mk_edit(ses_pkg::EDIT_DELETE, px_reg, py_reg, n_s, m_s);
                end else begin
                    buf_wdata = mk_edit(ses_pkg::EDIT_KEEP, px_reg, py_reg, n_s, m_s);
                end
                if (d_reg != '0 && cnt_reg <= CW'(DMAX)) begin
                    buf_we   = (cnt_reg < CW'(DMAX));
                    cnt_next = cnt_reg + 1'b1;
                end
                x_next = px_reg;
                y_next = py_reg;
                if (d_reg == '0) begin
                    if (cnt_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        oidx_next  = (cnt_reg > CW'(DMAX)) ? BAW'(DMAX - 1)
                                                           : BAW'(cnt_reg - 1'b1);
                        state_next = ST_O_RD;
                    end
                end else begin
                    d_next     = d_reg - 1'b1;
                    base_next  = base_reg - TW'(d_reg);
                    state_next = ST_B_RD1;
                end
            end
            ST_O_RD: begin
                state_next = ST_O_LOOK;
            end
            ST_O_LOOK: begin
                a_raddr    = buf_rdata.a_pos[AW-1:0];
                b_raddr    = buf_rdata.b_pos[AW-1:0];
                state_next = ST_O_EMIT;
            end
            ST_O_EMIT: begin
                result_strobe = 1'b1;
                if (oidx_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    oidx_next  = oidx_reg - 1'b1;
                    state_next = ST_O_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (!buf_rdata.in_range) begin
            val = '0;
        end else if (buf_rdata.kind == ses_pkg::EDIT_INSERT) begin
            val = b_rdata;
        end else begin
            val = a_rdata;
        end
        result.edit_kind  = buf_rdata.kind;
        result.a_position = buf_rdata.a_pos;
        result.b_position = buf_rdata.b_pos;
        result.edit_value = OW'(val);
        result.last       = (oidx_reg == '0);
    end

    always_ff @(posedge clk) begin
        if (we_a) begin
            mem_a[len_a_reg[AW-1:0]] <= cmd.element[SW-1:0];
        end
        if (we_b) begin
            mem_b[len_b_reg[AW-1:0]] <= cmd.element[SW-1:0];
        end
        a_rdata <= mem_a[a_raddr];
        b_rdata <= mem_b[b_raddr];
    end

    always_ff @(posedge clk) begin
        if (tr_we) begin
            mem_tr[tr_waddr] <= tr_wdata;
        end
        tr_rdata <= mem_tr[tr_raddr];
    end

    always_ff @(posedge clk) begin
        if (buf_we) begin
            mem_buf[cnt_reg[BAW-1:0]] <= buf_wdata;
        end
        buf_rdata <= mem_buf[oidx_reg];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            len_a_reg <= '0;
            len_b_reg <= '0;
        end else begin
            state_reg <= state_next;
            len_a_reg <= len_a_next;
            len_b_reg <= len_b_next;
        end
    end

    always_ff @(posedge clk) begin
        n_reg    <= n_next;
        m_reg    <= m_next;
        d_reg    <= d_next;
        idx_reg  <= idx_next;
        base_reg <= base_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        cnt_reg  <= cnt_next;
        oidx_reg <= oidx_next;
    end

    // A result only appears while a run is in progress.
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> busy)
        else $error("result strobe while idle");

    // The final edit of a script returns the block to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.last |=> !busy)
        else $error("block still busy after final edit");

    // A run with both sequences empty produces nothing and ends at once.
    a_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.kind == ses_pkg::KIND_RUN &&
        len_a_reg == '0 && len_b_reg == '0 |=> !busy)
        else $error("empty run did not finish immediately");

    // Lengths are cleared by every run.
    a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.kind == ses_pkg::KIND_RUN |=>
        len_a_reg == '0 && len_b_reg == '0)
        else $error("lengths not cleared by run");

endmodule
